@@ rtl/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and codes of the swap slot allocator: command format, status
// and sector operation codes, engine states and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

   // field widths
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned INDEX_W   = 10;
   localparam int unsigned COUNT_W   = 11;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned SLOT_W    = 10;
   localparam int unsigned SECOP_W   = 2;
   localparam int unsigned SECTOR_W  = 13;

   // free map rows
   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned BIT_W     = 5;

   // register port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        REG_SLOT_COUNT = 1'b0;
   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SWAPIN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADIDX = 2'd2;

   // sector operations
   localparam logic [SECOP_W-1:0] SECOP_NONE  = 2'd0;
   localparam logic [SECOP_W-1:0] SECOP_WRITE = 2'd1;
   localparam logic [SECOP_W-1:0] SECOP_READ  = 2'd2;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_SWAPIN,
      CMD_FREE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [INDEX_W-1:0]  index;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } eng_state_type;

endpackage

`default_nettype wire

@@ rtl/ssa_queue.sv @@
// ----------------------------------------------------------------------------
// ssa_queue
// Two-entry command queue between the request front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_queue import ssa_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_data
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign pop_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ssa_engine.sv @@
// ----------------------------------------------------------------------------
// ssa_engine
// Back end: free map memory (one row of 32 slots per word), first-fit scan
// from a lowest-free-row hint, checked free, and the sector result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_engine import ssa_pkg::*; #(
   parameter int unsigned SLOTS            = 1024,
   parameter int unsigned SECTORS_PER_SLOT = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [COUNT_W-1:0]   slot_count,
   input  wire logic                 cmd_valid,
   input  wire cmd_type              cmd,
   output logic                      cmd_pop,
   output logic                      clearing,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic [SECOP_W-1:0]        rsp_sector_op,
   output logic [SECTOR_W-1:0]       rsp_sector,
   output logic                      rsp_last
);

   localparam int unsigned ROWS   = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned LEFT_W = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
   localparam logic [ROW_W-1:0]  LAST_ROW          = ROW_W'(ROWS - 1);
   localparam logic [LEFT_W-1:0] BEATS_AFTER_FIRST = LEFT_W'(SECTORS_PER_SLOT - 1);

   // free map: bit set means slot free
   logic [WORD_BITS-1:0] map_mem [ROWS];
   logic [WORD_BITS-1:0] rd_data_ff;

   eng_state_type        state_ff, state_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ROW_W-1:0]     hint_ff, hint_in;
   cmd_type              cmd_ff, cmd_in;

   logic                 rd_en;
   logic [ROW_W-1:0]     rd_row;
   logic                 wr_en;
   logic [ROW_W-1:0]     wr_row;
   logic [WORD_BITS-1:0] wr_data;

   logic [COUNT_W-1:0]   active_n;
   logic [31:0]          active_n32;
   logic [31:0]          row_base;
   logic [WORD_BITS-1:0] act_mask;
   logic [WORD_BITS-1:0] masked;
   logic [BIT_W-1:0]     hit_bit;
   logic [31:0]          hit_slot32;
   logic [WORD_BITS-1:0] cleared_row;
   logic [31:0]          idx32;
   logic [BIT_W-1:0]     idx_bit;
   logic [WORD_BITS-1:0] set_row;
   logic                 scan_end;
   logic                 idx_ok;

   logic                 start;
   logic [STATUS_W-1:0]  st_status;
   logic [31:0]          st_slot32;
   logic [SECOP_W-1:0]   st_secop;
   logic                 st_multi;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [SECOP_W-1:0]   secop_ff, secop_in;
   logic [SECTOR_W-1:0]  sector_ff, sector_in;
   logic                 last_ff, last_in;
   logic [LEFT_W-1:0]    left_ff, left_in;

   assign clearing      = (state_ff == ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_sector_op = secop_ff;
   assign rsp_sector    = sector_ff;
   assign rsp_last      = last_ff;

   always_comb begin
      if (32'(slot_count) > SLOTS) begin
         active_n = COUNT_W'(SLOTS);
      end else begin
         active_n = slot_count;
      end
   end

   assign active_n32 = 32'(active_n);
   assign row_base   = 32'(row_ff) << BIT_W;
   assign scan_end   = (row_base + WORD_BITS >= active_n32);

   // slots of this row that lie below the active count
   always_comb begin
      if (active_n32 >= row_base + WORD_BITS) begin
         act_mask = '1;
      end else if (active_n32 <= row_base) begin
         act_mask = '0;
      end else begin
         act_mask = WORD_BITS'((32'(1) << (active_n32 - row_base)) - 32'(1));
      end
   end

   assign masked = rd_data_ff & act_mask;

   // lowest free bit
   always_comb begin
      hit_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (masked[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   assign hit_slot32  = row_base | 32'(hit_bit);
   assign cleared_row = rd_data_ff & ~(WORD_BITS'(1) << hit_bit);
   assign idx32       = 32'(cmd_ff.index);
   assign idx_bit     = cmd_ff.index[BIT_W-1:0];
   assign set_row     = rd_data_ff | (WORD_BITS'(1) << idx_bit);
   assign idx_ok      = (idx32 < active_n32) && !rd_data_ff[idx_bit];

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      hint_in   = hint_ff;
      cmd_in    = cmd_ff;
      rd_en     = 1'b0;
      rd_row    = row_ff;
      wr_en     = 1'b0;
      wr_row    = row_ff;
      wr_data   = rd_data_ff;
      cmd_pop   = 1'b0;
      start     = 1'b0;
      st_status = STATUS_OK;
      st_slot32 = '0;
      st_secop  = SECOP_NONE;
      st_multi  = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '1;
            hint_in = '0;
            if (row_ff == LAST_ROW) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end

         ST_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               rd_en   = 1'b1;
               if (cmd.op == CMD_ALLOC) begin
                  rd_row = hint_ff;
               end else begin
                  rd_row = ROW_W'(32'(cmd.index) >> BIT_W);
               end
               row_in   = rd_row;
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            unique case (cmd_ff.op)
               CMD_ALLOC: begin
                  if (masked != '0) begin
                     wr_en     = 1'b1;
                     wr_data   = cleared_row;
                     start     = 1'b1;
                     st_status = STATUS_OK;
                     st_slot32 = hit_slot32;
                     st_secop  = SECOP_WRITE;
                     st_multi  = 1'b1;
                     if (cleared_row == '0 && hint_ff == row_ff && row_ff != LAST_ROW) begin
                        hint_in = row_ff + ROW_W'(1);
                     end
                     state_in = ST_IDLE;
                  end else if (scan_end) begin
                     start     = 1'b1;
                     st_status = STATUS_FULL;
                     state_in  = ST_IDLE;
                  end else begin
                     // advance to the next row; skip the hint past a full row
                     if (rd_data_ff == '0 && hint_ff == row_ff) begin
                        hint_in = row_ff + ROW_W'(1);
                     end
                     rd_en  = 1'b1;
                     rd_row = row_ff + ROW_W'(1);
                     row_in = rd_row;
                  end
               end

               CMD_SWAPIN, CMD_FREE: begin
                  start     = 1'b1;
                  st_slot32 = idx32;
                  state_in  = ST_IDLE;
                  if (!idx_ok) begin
                     st_status = STATUS_BADIDX;
                  end else begin
                     wr_en     = 1'b1;
                     wr_data   = set_row;
                     st_status = STATUS_OK;
                     if (row_ff < hint_ff) begin
                        hint_in = row_ff;
                     end
                     if (cmd_ff.op == CMD_SWAPIN) begin
                        st_secop = SECOP_READ;
                        st_multi = 1'b1;
                     end
                  end
               end

               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         row_ff   <= '0;
         hint_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         hint_ff  <= hint_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_row];
      end
   end

   // result emitter: one result per transfer, sectors counted up
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      secop_in     = secop_ff;
      sector_in    = sector_ff;
      last_in      = last_ff;
      left_in      = left_ff;
      if (start) begin
         rsp_valid_in = 1'b1;
         status_in    = st_status;
         slot_in      = SLOT_W'(st_slot32);
         secop_in     = st_secop;
         sector_in    = st_multi ? SECTOR_W'(st_slot32 * SECTORS_PER_SLOT) : '0;
         last_in      = st_multi ? (SECTORS_PER_SLOT == 1) : 1'b1;
         left_in      = BEATS_AFTER_FIRST;
      end else if (rsp_valid_ff && rsp_ready) begin
         if (last_ff) begin
            rsp_valid_in = 1'b0;
         end else begin
            sector_in = sector_ff + SECTOR_W'(1);
            left_in   = left_ff - LEFT_W'(1);
            last_in   = (left_ff == LEFT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      slot_ff   <= slot_in;
      secop_ff  <= secop_in;
      sector_ff <= sector_in;
      last_ff   <= last_in;
      left_ff   <= left_in;
   end

endmodule

`default_nettype wire

@@ rtl/swap_slot_allocator_core.sv @@
// Flow: with the engine idle, a request transfer passes the command queue to
//   the engine, where an allocate scans the free map one row of 32 slots per
//   cycle from the lowest-free-row hint; then one result per cycle while
//   rsp_ready is high. The engine drains each result train before its next
//   lookup, so it takes no new command from the queue until every result of
//   the last one has been taken.
// Reset: the free map is set to all free by a pass over its ceil(SLOTS/32)
//   rows (32 at the defaults); req_ready stays low until it ends.
// ----------------------------------------------------------------------------
// swap_slot_allocator_core
// First-fit swap slot allocator: request front end, command queue, engine
// and register port.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_slot_allocator_core import ssa_pkg::*; #(
   parameter int unsigned SLOTS            = 1024,
   parameter int unsigned SECTORS_PER_SLOT = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [MODE_W-1:0]       req_mode,
   input  wire logic [INDEX_W-1:0]      req_slot_index,

   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [SLOT_W-1:0]            rsp_slot,
   output logic [SECOP_W-1:0]           rsp_sector_op,
   output logic [SECTOR_W-1:0]          rsp_sector,
   output logic                         rsp_last,

   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   logic [COUNT_W-1:0] slot_count_ff, slot_count_in;
   logic               csr_hit;

   logic               q_full;
   logic               q_push;
   cmd_type            q_push_data;
   logic               q_pop;
   logic               q_pop_valid;
   cmd_type            q_pop_data;
   logic               clearing;
   logic               req_xfer;

   // register port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_SLOT_COUNT);

   always_comb begin
      slot_count_in = slot_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         slot_count_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      if (csr_hit) begin
         csr_prdata = CSR_DATA_W'(slot_count_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
      end else begin
         slot_count_ff <= slot_count_in;
      end
   end

   // front end: classify the request, drop the unused mode
   assign req_ready = !q_full && !clearing;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      q_push            = 1'b0;
      q_push_data.index = req_slot_index;
      q_push_data.op    = CMD_ALLOC;
      unique case (req_mode)
         MODE_ALLOC: begin
            q_push         = req_xfer;
            q_push_data.op = CMD_ALLOC;
         end
         MODE_SWAPIN: begin
            q_push         = req_xfer;
            q_push_data.op = CMD_SWAPIN;
         end
         MODE_FREE: begin
            q_push         = req_xfer;
            q_push_data.op = CMD_FREE;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   ssa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_pop_valid),
      .pop_data  (q_pop_data)
   );

   ssa_engine #(
      .SLOTS            (SLOTS),
      .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .slot_count    (slot_count_ff),
      .cmd_valid     (q_pop_valid),
      .cmd           (q_pop_data),
      .cmd_pop       (q_pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_slot      (rsp_slot),
      .rsp_sector_op (rsp_sector_op),
      .rsp_sector    (rsp_sector),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

@@ test/swap_slot_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_allocator_core_tb
// Self-checking bench for the first-fit swap slot allocator. Requests go in
// through a bursty valid/ready driver, results are checked field by field by
// a monitor against a free-map model kept inside the bench, and the slot
// count register is reprogrammed between drained phases.
// ----------------------------------------------------------------------------

module swap_slot_allocator_core_tb;
   import ssa_pkg::*;

   localparam int unsigned SLOTS            = 1024;
   localparam int unsigned SECTORS_PER_SLOT = 8;
   localparam int unsigned IDLE_SETTLE      = 80;
   localparam int unsigned ITEMS_PER_PHASE  = 75;
   localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] SLOT_COUNT_ADDR = CSR_ADDR_W'(4 * REG_SLOT_COUNT);

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] index;
   } slot_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [SECOP_W-1:0]  op;
      logic [SECTOR_W-1:0] sector;
      logic                last;
   } sector_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode       = '0;
   logic [INDEX_W-1:0]    req_slot_index = '0;

   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_slot;
   logic [SECOP_W-1:0]    rsp_sector_op;
   logic [SECTOR_W-1:0]   rsp_sector;
   logic                  rsp_last;

   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   swap_slot_allocator_core #(
      .SLOTS            (SLOTS),
      .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_sector_op  (rsp_sector_op),
      .rsp_sector     (rsp_sector),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #1 clock = ~clock;

   // free map model and its configuration
   logic                 slot_is_free [SLOTS];
   logic [COUNT_W-1:0]   slot_count_q = SLOT_COUNT_RESET;

   slot_req_type         pending_reqs [$];
   sector_result_type    results_due [$];
   int unsigned          n_pushed = 0;
   int unsigned          n_taken  = 0;
   int unsigned          n_errors = 0;

   initial begin
      foreach (slot_is_free[s]) slot_is_free[s] = 1'b1;
   end

   function automatic int unsigned usable_slots();
      return (slot_count_q > SLOTS) ? SLOTS : int'(slot_count_q);
   endfunction

   task automatic queue_page(input int unsigned slot, input logic [SECOP_W-1:0] op);
      sector_result_type r;
      for (int i = 0; i < SECTORS_PER_SLOT; i++) begin
         r.status = STATUS_OK;
         r.slot   = SLOT_W'(slot);
         r.op     = op;
         r.sector = SECTOR_W'(slot * SECTORS_PER_SLOT + i);
         r.last   = (i == SECTORS_PER_SLOT - 1);
         results_due.push_back(r);
      end
   endtask

   // apply one accepted request to the free map and queue what it yields
   task automatic allocate_or_release(input logic [MODE_W-1:0] mode,
                                      input logic [INDEX_W-1:0] idx);
      int unsigned       n;
      int                found;
      sector_result_type r;
      n     = usable_slots();
      found = -1;
      r     = '{status: STATUS_OK, slot: '0, op: SECOP_NONE, sector: '0, last: 1'b1};
      case (mode)
         MODE_ALLOC: begin
            for (int s = 0; s < n; s++)
               if (found < 0 && slot_is_free[s]) found = s;
            if (found < 0) begin
               r.status = STATUS_FULL;
               results_due.push_back(r);
            end else begin
               slot_is_free[found] = 1'b0;
               queue_page(found, SECOP_WRITE);
            end
         end
         MODE_SWAPIN, MODE_FREE: begin
            r.slot = idx;
            if (idx >= n || slot_is_free[idx]) begin
               r.status = STATUS_BADIDX;
               results_due.push_back(r);
            end else begin
               if (mode == MODE_SWAPIN) queue_page(idx, SECOP_READ);
               else results_due.push_back(r);
               slot_is_free[idx] = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      n_errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // ---------------- driver ----------------
   slot_req_type next_req;
   int unsigned  burst_left = 0;
   int unsigned  gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            allocate_or_release(req_mode, req_slot_index);
            n_taken <= n_taken + 1;
         end
         if (req_valid && !req_ready) begin
            // hold until the transfer completes
         end else if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            next_req       = pending_reqs.pop_front();
            req_valid      <= 1'b1;
            req_mode       <= next_req.mode;
            req_slot_index <= next_req.index;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------
   sector_result_type got_want;
   int unsigned       stall_left  = 0;
   int unsigned       stall_style = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_left  <= 0;
         stall_style <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result slot %0d sector %0d",
                                         rsp_slot, rsp_sector));
            end else begin
               got_want = results_due.pop_front();
               check_field("status", rsp_status, got_want.status);
               check_field("slot", rsp_slot, got_want.slot);
               check_field("sector_op", rsp_sector_op, got_want.op);
               check_field("sector", rsp_sector, got_want.sector);
               check_field("last", rsp_last, got_want.last);
            end
         end
         if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(8, 40);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_style)
            2:       rsp_ready <= $urandom_range(0, 1);
            3:       rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // ---------------- stimulus ----------------
   task automatic push_req(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx);
      @(negedge clock);
      while (pending_reqs.size() >= 4) @(negedge clock);
      pending_reqs.push_back('{mode: mode, index: idx});
      n_pushed++;
   endtask

   task automatic wait_idle(input int unsigned settle);
      @(negedge clock);
      while (n_taken != n_pushed || results_due.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == SLOT_COUNT_ADDR) slot_count_q = data[COUNT_W-1:0];
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] phase_counts [6];
      int unsigned           used_slots [$];
      int unsigned           alloc_pct;
      int unsigned           made;
      int unsigned           pick;
      phase_counts = '{32'd2047, 32'hFFFF_F805, 32'd1024, 32'd33, 32'd1023, 32'd64};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset slot count: first fit, reuse of the lowest freed slot, bad indexes
      push_req(MODE_ALLOC, 10'd0);
      push_req(MODE_ALLOC, 10'd0);
      push_req(MODE_ALLOC, 10'd0);
      push_req(MODE_SWAPIN, 10'd1);
      push_req(MODE_FREE, 10'd0);
      push_req(MODE_FREE, 10'd0);
      push_req(MODE_SWAPIN, 10'd0);
      push_req(MODE_ALLOC, 10'd0);
      push_req(MODE_ALLOC, 10'd0);
      push_req(MODE_FREE, 10'd1023);
      push_req(MODE_SWAPIN, 10'd1023);
      push_req(MODE_NOP, 10'd1023);
      push_req(MODE_NOP, 10'd0);
      push_req(MODE_FREE, 10'd2);
      push_req(MODE_ALLOC, 10'd1023);
      push_req(MODE_SWAPIN, 10'h2AA);
      push_req(MODE_FREE, 10'h155);

      // no usable slots: full on allocate, used slots out of range
      wait_idle(IDLE_SETTLE);
      csr_write(SLOT_COUNT_ADDR, 32'd0);
      push_req(MODE_ALLOC, 10'd0);
      push_req(MODE_SWAPIN, 10'd0);
      push_req(MODE_FREE, 10'd1);

      // single usable slot
      wait_idle(IDLE_SETTLE);
      csr_write(SLOT_COUNT_ADDR, 32'd1);
      push_req(MODE_ALLOC, 10'd0);
      push_req(MODE_FREE, 10'd0);
      push_req(MODE_ALLOC, 10'd0);
      push_req(MODE_ALLOC, 10'd0);
      push_req(MODE_SWAPIN, 10'd0);
      push_req(MODE_SWAPIN, 10'd1);

      foreach (phase_counts[p]) begin
         wait_idle(IDLE_SETTLE);
         csr_write(SLOT_COUNT_ADDR, phase_counts[p]);
         alloc_pct = $urandom_range(25, 60);
         made = 0;
         while (made < ITEMS_PER_PHASE) begin
            if (p == 2 && made == ITEMS_PER_PHASE / 2) wait_idle(0);
            used_slots.delete();
            for (int s = 0; s < usable_slots(); s++)
               if (!slot_is_free[s]) used_slots.push_back(s);
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
               push_req(MODE_ALLOC, INDEX_W'($urandom));
               made++;
            end else if (pick < alloc_pct + 30 && used_slots.size() != 0) begin
               push_req($urandom_range(0, 1) ? MODE_SWAPIN : MODE_FREE,
                        INDEX_W'(used_slots[$urandom_range(0, used_slots.size() - 1)]));
               made++;
            end else if (pick < 95) begin
               push_req($urandom_range(0, 1) ? MODE_SWAPIN : MODE_FREE, INDEX_W'($urandom));
               made++;
            end else begin
               push_req(MODE_NOP, INDEX_W'($urandom));
            end
         end
      end

      wait_idle(IDLE_SETTLE);
      if (n_errors == 0) begin
         $display("swap_slot_allocator_core: match");
      end else begin
         $display("swap_slot_allocator_core: mismatch");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("swap_slot_allocator_core: mismatch");
      $finish;
   end

endmodule
